// ===== rtl/ccsg_pkg.sv =====
`default_nettype none

package ccsg_pkg;

  localparam int STEPS      = 20;
  localparam int COORD_BITS = 12;
  localparam int IN_W       = 12;
  localparam int OUT_W      = 22;
  localparam int FRAC       = 16;

  localparam int CW     = COORD_BITS;
  localparam int NUM_W  = CW + 8;
  localparam int Q_W    = NUM_W - 1;
  localparam int ACC_W  = CW + 23;
  localparam int T_W    = FRAC + 1;
  localparam int PROD_W = ACC_W + T_W + 1;
  localparam int K_W    = $clog2(STEPS + 1);

  // numerators are biased positive before the divide by three
  localparam int NUM_OFF = 3 << (CW + 5);
  localparam int Q_OFF   = 1 << (CW + 5);
  localparam int RCP_SH  = NUM_W + 2;
  localparam int RCP_W   = RCP_SH - 1;
  localparam int RCP     = ((1 << RCP_SH) + 2) / 3;
  localparam int THIRD1  = ((1 << FRAC) + 1) / 3;
  localparam int THIRD2  = ((2 << FRAC) + 1) / 3;

  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (OUT_W - 1));

  typedef struct packed {
    logic [IN_W-1:0] end_a_x;
    logic [IN_W-1:0] end_a_ytop;
    logic [IN_W-1:0] end_a_ybot;
    logic [IN_W-1:0] end_b_x;
    logic [IN_W-1:0] end_b_ytop;
    logic [IN_W-1:0] end_b_ybot;
    logic [IN_W-1:0] near_x;
    logic [IN_W-1:0] near_ytop;
    logic [IN_W-1:0] near_ybot;
    logic [IN_W-1:0] far_x;
    logic [IN_W-1:0] far_ytop;
    logic [IN_W-1:0] far_ybot;
  } curve_in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] c3;
    logic signed [ACC_W-1:0] c2;
    logic signed [ACC_W-1:0] c1;
    logic signed [ACC_W-1:0] c0;
  } axis_coef_t;

  typedef struct packed {
    axis_coef_t cx;
    axis_coef_t cy;
  } curve_coef_t;

  typedef struct packed {
    curve_coef_t      coef;
    logic [T_W-1:0]   t;
    logic             first;
    logic             last;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/cubic_curve_segment_generator_unit.sv =====
// a segment passes the coefficient stages, sequencer, horner stages, output register
// each curve gives STEPS+1 (21) segments, one per cycle when the output is not stalled
// the segment sequencer loads a new curve as it issues the last t sample
// and issues one t sample per cycle, unless stalled, into the 7 stage horner pipeline
// reset: rst_ni is asynchronous, active low, and clears all valid and sequencer state
`default_nettype none

module cubic_curve_segment_generator_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ccsg_pkg::IN_W-1:0]         end_a_x_i,
  input  logic [ccsg_pkg::IN_W-1:0]         end_a_ytop_i,
  input  logic [ccsg_pkg::IN_W-1:0]         end_a_ybot_i,
  input  logic [ccsg_pkg::IN_W-1:0]         end_b_x_i,
  input  logic [ccsg_pkg::IN_W-1:0]         end_b_ytop_i,
  input  logic [ccsg_pkg::IN_W-1:0]         end_b_ybot_i,
  input  logic [ccsg_pkg::IN_W-1:0]         near_x_i,
  input  logic [ccsg_pkg::IN_W-1:0]         near_ytop_i,
  input  logic [ccsg_pkg::IN_W-1:0]         near_ybot_i,
  input  logic [ccsg_pkg::IN_W-1:0]         far_x_i,
  input  logic [ccsg_pkg::IN_W-1:0]         far_ytop_i,
  input  logic [ccsg_pkg::IN_W-1:0]         far_ybot_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ccsg_pkg::OUT_W-1:0] cur_x_o,
  output logic signed [ccsg_pkg::OUT_W-1:0] cur_y_o,
  output logic signed [ccsg_pkg::OUT_W-1:0] prev_x_o,
  output logic signed [ccsg_pkg::OUT_W-1:0] prev_y_o,
  output logic                              last_segment_o
);
  import ccsg_pkg::*;

  curve_in_t   in_pts;
  curve_coef_t coef;
  logic        coef_valid;
  logic        coef_ready;
  job_t        job;
  logic        job_valid;
  logic        job_ready;

  assign in_pts.end_a_x    = end_a_x_i;
  assign in_pts.end_a_ytop = end_a_ytop_i;
  assign in_pts.end_a_ybot = end_a_ybot_i;
  assign in_pts.end_b_x    = end_b_x_i;
  assign in_pts.end_b_ytop = end_b_ytop_i;
  assign in_pts.end_b_ybot = end_b_ybot_i;
  assign in_pts.near_x     = near_x_i;
  assign in_pts.near_ytop  = near_ytop_i;
  assign in_pts.near_ybot  = near_ybot_i;
  assign in_pts.far_x      = far_x_i;
  assign in_pts.far_ytop   = far_ytop_i;
  assign in_pts.far_ybot   = far_ybot_i;

  ccsg_coef u_coef (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_pts),
    .coef_valid_o (coef_valid),
    .coef_ready_i (coef_ready),
    .coef_o       (coef)
  );

  ccsg_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coef_valid_i (coef_valid),
    .coef_ready_o (coef_ready),
    .coef_i       (coef),
    .job_valid_o  (job_valid),
    .job_ready_i  (job_ready),
    .job_o        (job)
  );

  ccsg_eval u_eval (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_ready_o    (job_ready),
    .job_i          (job),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cur_x_o        (cur_x_o),
    .cur_y_o        (cur_y_o),
    .prev_x_o       (prev_x_o),
    .prev_y_o       (prev_y_o),
    .last_segment_o (last_segment_o)
  );

endmodule

`default_nettype wire

// ===== rtl/ccsg_coef.sv =====
`default_nettype none

module ccsg_coef (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ccsg_pkg::curve_in_t    in_i,
  output logic                   coef_valid_o,
  input  logic                   coef_ready_i,
  output ccsg_pkg::curve_coef_t  coef_o
);
  import ccsg_pkg::*;

  typedef struct packed {
    logic [3:0][CW-1:0] x;
    logic [3:0][CW-1:0] y;
  } pts_t;

  typedef struct packed {
    logic [5:0][NUM_W-1:0] n;
    logic [CW-1:0]         x0;
    logic [CW-1:0]         y0;
  } num_t;

  typedef struct packed {
    logic [5:0][Q_W-1:0] q;
    logic [5:0][1:0]     n_lo;
    logic [CW-1:0]       x0;
    logic [CW-1:0]       y0;
  } quo_t;

  localparam logic signed [ACC_W-1:0] A_QOFF = ACC_W'(Q_OFF);

  function automatic logic [2:0][NUM_W-1:0] numer(input logic [CW-1:0] p0,
                                                   input logic [CW-1:0] p1,
                                                   input logic [CW-1:0] p2,
                                                   input logic [CW-1:0] p3);
    int a;
    int b;
    int c;
    int d;
    logic [2:0][NUM_W-1:0] r;
    a = int'(p0);
    b = int'(p1);
    c = int'(p2);
    d = int'(p3);
    r[0] = NUM_W'(16 * d - 32 * c + 32 * b - 16 * a + NUM_OFF);
    r[1] = NUM_W'(-16 * d + 40 * c - 56 * b + 32 * a + NUM_OFF);
    r[2] = NUM_W'(3 * d - 8 * c + 24 * b - 19 * a + NUM_OFF);
    return r;
  endfunction

  function automatic logic [FRAC-1:0] third_frac(input logic [1:0] r);
    logic [FRAC-1:0] f;
    unique case (r)
      2'd1:    f = FRAC'(THIRD1);
      2'd2:    f = FRAC'(THIRD2);
      default: f = '0;
    endcase
    return f;
  endfunction

  function automatic logic [CW-1:0] avg(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a[CW-1:0]} + {1'b0, b[CW-1:0]};
    return s[CW:1];
  endfunction

  logic [3:0] v_q;
  logic [3:0] v_d;
  logic [3:0] en;

  pts_t        pts_q;
  pts_t        pts_d;
  num_t        num_q;
  num_t        num_d;
  quo_t        quo_q;
  quo_t        quo_d;
  curve_coef_t coef_q;
  curve_coef_t coef_d;

  always_comb begin
    en[3] = !v_q[3] || coef_ready_i;
    en[2] = !v_q[2] || en[3];
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    v_d[1] = en[1] ? v_q[0] : v_q[1];
    v_d[2] = en[2] ? v_q[1] : v_q[2];
    v_d[3] = en[3] ? v_q[2] : v_q[3];
  end

  // stage 1: average y pairs, order the ends by x
  always_comb begin
    logic [CW-1:0] ax;
    logic [CW-1:0] bx;
    logic [CW-1:0] ay;
    logic [CW-1:0] by;
    ax = in_i.end_a_x[CW-1:0];
    bx = in_i.end_b_x[CW-1:0];
    ay = avg(in_i.end_a_ytop, in_i.end_a_ybot);
    by = avg(in_i.end_b_ytop, in_i.end_b_ybot);
    pts_d.x[1] = in_i.near_x[CW-1:0];
    pts_d.y[1] = avg(in_i.near_ytop, in_i.near_ybot);
    pts_d.x[2] = in_i.far_x[CW-1:0];
    pts_d.y[2] = avg(in_i.far_ytop, in_i.far_ybot);
    if (ax < bx) begin
      pts_d.x[0] = ax;
      pts_d.y[0] = ay;
      pts_d.x[3] = bx;
      pts_d.y[3] = by;
    end else begin
      pts_d.x[0] = bx;
      pts_d.y[0] = by;
      pts_d.x[3] = ax;
      pts_d.y[3] = ay;
    end
  end

  // stage 2: biased numerators
  always_comb begin
    logic [2:0][NUM_W-1:0] nx;
    logic [2:0][NUM_W-1:0] ny;
    nx = numer(pts_q.x[0], pts_q.x[1], pts_q.x[2], pts_q.x[3]);
    ny = numer(pts_q.y[0], pts_q.y[1], pts_q.y[2], pts_q.y[3]);
    for (int i = 0; i < 3; i++) begin
      num_d.n[i]     = nx[i];
      num_d.n[i + 3] = ny[i];
    end
    num_d.x0 = pts_q.x[0];
    num_d.y0 = pts_q.y[0];
  end

  // stage 3: quotient by three through the reciprocal
  always_comb begin
    logic [NUM_W+RCP_W-1:0] prod;
    for (int i = 0; i < 6; i++) begin
      prod = (NUM_W + RCP_W)'(num_q.n[i]) * (NUM_W + RCP_W)'(RCP);
      quo_d.q[i]    = prod[RCP_SH +: Q_W];
      quo_d.n_lo[i] = num_q.n[i][1:0];
    end
    quo_d.x0 = num_q.x0;
    quo_d.y0 = num_q.y0;
  end

  // stage 4: q16 coefficients from quotient and remainder
  always_comb begin
    logic [5:0][ACC_W-1:0] c;
    logic [1:0]              r;
    logic signed [ACC_W-1:0] a;
    for (int i = 0; i < 6; i++) begin
      r    = quo_q.n_lo[i] - quo_q.q[i][1:0] - {quo_q.q[i][0], 1'b0};
      a    = $signed(ACC_W'(quo_q.q[i])) - A_QOFF;
      c[i] = (a <<< FRAC) + $signed(ACC_W'(third_frac(r)));
    end
    coef_d.cx.c3 = c[0];
    coef_d.cx.c2 = c[1];
    coef_d.cx.c1 = c[2];
    coef_d.cx.c0 = $signed(ACC_W'(quo_q.x0)) <<< FRAC;
    coef_d.cy.c3 = c[3];
    coef_d.cy.c2 = c[4];
    coef_d.cy.c1 = c[5];
    coef_d.cy.c0 = $signed(ACC_W'(quo_q.y0)) <<< FRAC;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pts_q <= pts_d;
    end
    if (en[1]) begin
      num_q <= num_d;
    end
    if (en[2]) begin
      quo_q <= quo_d;
    end
    if (en[3]) begin
      coef_q <= coef_d;
    end
  end

  assign in_ready_o   = en[0];
  assign coef_valid_o = v_q[3];
  assign coef_o       = coef_q;

endmodule

`default_nettype wire

// ===== rtl/ccsg_seq.sv =====
`default_nettype none

module ccsg_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   coef_valid_i,
  output logic                   coef_ready_o,
  input  ccsg_pkg::curve_coef_t  coef_i,
  output logic                   job_valid_o,
  input  logic                   job_ready_i,
  output ccsg_pkg::job_t         job_o
);
  import ccsg_pkg::*;

  localparam logic [K_W-1:0] K_LAST = K_W'(STEPS);

  logic [T_W-1:0] t_tbl [STEPS+1];

  for (genvar g = 0; g <= STEPS; g++) begin : g_t
    assign t_tbl[g] = T_W'((g * (2 << FRAC) + STEPS) / (2 * STEPS));
  end

  logic           busy_q;
  logic           busy_d;
  logic [K_W-1:0] k_q;
  logic [K_W-1:0] k_d;
  curve_coef_t    coef_q;
  logic           last_k;
  logic           issue;
  logic           load;

  assign last_k       = (k_q == K_LAST);
  assign issue        = busy_q && job_ready_i;
  assign coef_ready_o = !busy_q || (job_ready_i && last_k);
  assign load         = coef_valid_i && coef_ready_o;

  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    if (load) begin
      busy_d = 1'b1;
      k_d    = '0;
    end else if (issue) begin
      if (last_k) begin
        busy_d = 1'b0;
      end else begin
        k_d = k_q + K_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      coef_q <= coef_i;
    end
  end

  assign job_valid_o = busy_q;
  assign job_o.coef  = coef_q;
  assign job_o.t     = t_tbl[k_q];
  assign job_o.first = (k_q == '0);
  assign job_o.last  = last_k;

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (k_q <= K_LAST))
    else $error("sample index past last step");

  a_k_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && !last_k) |=> (busy_q && (k_q == $past(k_q) + K_W'(1))))
    else $error("sample index did not advance");

endmodule

`default_nettype wire

// ===== rtl/ccsg_eval.sv =====
`default_nettype none

module ccsg_eval (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_valid_i,
  output logic                           job_ready_o,
  input  ccsg_pkg::job_t                 job_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [ccsg_pkg::OUT_W-1:0] cur_x_o,
  output logic signed [ccsg_pkg::OUT_W-1:0] cur_y_o,
  output logic signed [ccsg_pkg::OUT_W-1:0] prev_x_o,
  output logic signed [ccsg_pkg::OUT_W-1:0] prev_y_o,
  output logic                           last_segment_o
);
  import ccsg_pkg::*;

  localparam int NS = 7;

  localparam logic signed [PROD_W-1:0] P_HALF  = PROD_W'(1) <<< (FRAC - 1);
  localparam logic signed [ACC_W-1:0]  A_HALF8 = ACC_W'(1) <<< (FRAC - 9);
  localparam logic signed [ACC_W-1:0]  A_OMAX  = ACC_W'(OUT_MAX);
  localparam logic signed [ACC_W-1:0]  A_OMIN  = ACC_W'(OUT_MIN);

  typedef struct packed {
    logic signed [PROD_W-1:0] ax;
    logic signed [PROD_W-1:0] ay;
    curve_coef_t              coef;
    logic [T_W-1:0]           t;
    logic                     first;
    logic                     last;
  } stg_t;

  function automatic logic signed [PROD_W-1:0] mul_t(input logic signed [ACC_W-1:0] a,
                                                     input logic [T_W-1:0] t);
    logic signed [PROD_W-1:0] r;
    r = a * $signed({1'b0, t});
    return r;
  endfunction

  function automatic logic signed [PROD_W-1:0] rnd_add(input logic signed [PROD_W-1:0] p,
                                                       input logic signed [ACC_W-1:0] c);
    logic signed [PROD_W-1:0] r;
    logic signed [ACC_W-1:0]  s;
    r = (p + P_HALF) >>> FRAC;
    s = r[ACC_W-1:0];
    s = s + c;
    return PROD_W'(s);
  endfunction

  function automatic logic signed [OUT_W-1:0] to_q8(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    logic signed [OUT_W-1:0] o;
    r = (a + A_HALF8) >>> (FRAC - 8);
    if (r > A_OMAX) begin
      o = OUT_W'(OUT_MAX);
    end else if (r < A_OMIN) begin
      o = OUT_W'(OUT_MIN);
    end else begin
      o = r[OUT_W-1:0];
    end
    return o;
  endfunction

  stg_t    st_q  [NS];
  stg_t    st_d  [NS];
  stg_t    src   [NS];
  logic [NS-1:0] v_q;
  logic [NS-1:0] v_d;
  logic [NS-1:0] src_v;
  logic [NS-1:0] en;

  logic                    out_valid_q;
  logic                    out_en;
  logic                    out_load;
  logic signed [OUT_W-1:0] cur_x_q;
  logic signed [OUT_W-1:0] cur_y_q;
  logic signed [OUT_W-1:0] prev_x_q;
  logic signed [OUT_W-1:0] prev_y_q;
  logic                    last_q;
  logic signed [OUT_W-1:0] new_x;
  logic signed [OUT_W-1:0] new_y;

  assign out_en   = !out_valid_q || out_ready_i;
  assign out_load = out_en && v_q[NS-1];

  always_comb begin
    src[0].ax    = '0;
    src[0].ay    = '0;
    src[0].coef  = job_i.coef;
    src[0].t     = job_i.t;
    src[0].first = job_i.first;
    src[0].last  = job_i.last;
    src_v[0]     = job_valid_i;
    for (int s = 1; s < NS; s++) begin
      src[s]   = st_q[s-1];
      src_v[s] = v_q[s-1];
    end
  end

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_en;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
    for (int s = 0; s < NS; s++) begin
      v_d[s] = en[s] ? src_v[s] : v_q[s];
    end
  end

  // horner steps, a multiply and a round-and-add in turn, then rounding and clamping to q8
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      st_d[s] = src[s];
      unique case (s)
        0: begin
          st_d[s].ax = mul_t(src[s].coef.cx.c3, src[s].t);
          st_d[s].ay = mul_t(src[s].coef.cy.c3, src[s].t);
        end
        1: begin
          st_d[s].ax = rnd_add(src[s].ax, src[s].coef.cx.c2);
          st_d[s].ay = rnd_add(src[s].ay, src[s].coef.cy.c2);
        end
        2, 4: begin
          st_d[s].ax = mul_t(src[s].ax[ACC_W-1:0], src[s].t);
          st_d[s].ay = mul_t(src[s].ay[ACC_W-1:0], src[s].t);
        end
        3: begin
          st_d[s].ax = rnd_add(src[s].ax, src[s].coef.cx.c1);
          st_d[s].ay = rnd_add(src[s].ay, src[s].coef.cy.c1);
        end
        5: begin
          st_d[s].ax = rnd_add(src[s].ax, src[s].coef.cx.c0);
          st_d[s].ay = rnd_add(src[s].ay, src[s].coef.cy.c0);
        end
        default: begin
          st_d[s].ax = PROD_W'(to_q8(src[s].ax[ACC_W-1:0]));
          st_d[s].ay = PROD_W'(to_q8(src[s].ay[ACC_W-1:0]));
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      v_q         <= v_d;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NS; s++) begin
      if (en[s]) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign new_x = st_q[NS-1].ax[OUT_W-1:0];
  assign new_y = st_q[NS-1].ay[OUT_W-1:0];

  // prev is the cur of the segment sent before, or cur itself on the first
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cur_x_q  <= new_x;
      cur_y_q  <= new_y;
      prev_x_q <= st_q[NS-1].first ? new_x : cur_x_q;
      prev_y_q <= st_q[NS-1].first ? new_y : cur_y_q;
      last_q   <= st_q[NS-1].last;
    end
  end

  assign job_ready_o    = en[0];
  assign out_valid_o    = out_valid_q;
  assign cur_x_o        = cur_x_q;
  assign cur_y_o        = cur_y_q;
  assign prev_x_o       = prev_x_q;
  assign prev_y_o       = prev_y_q;
  assign last_segment_o = last_q;

  a_tail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NS-1] && !en[NS-1]) |=> v_q[NS-1])
    else $error("stalled sample dropped from pipeline tail");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ccsg_pkg::*;

  localparam int GAP_MAX     = 18;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    longint c3;
    longint c2;
    longint c1;
    longint c0;
  } poly_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] cx;
    logic signed [OUT_W-1:0] cy;
    logic signed [OUT_W-1:0] px;
    logic signed [OUT_W-1:0] py;
    logic                    last;
  } seg_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  curve_in_t curve_drv = '0;
  logic in_ready_o;
  logic out_valid_o;
  logic signed [OUT_W-1:0] cur_x_o;
  logic signed [OUT_W-1:0] cur_y_o;
  logic signed [OUT_W-1:0] prev_x_o;
  logic signed [OUT_W-1:0] prev_y_o;
  logic last_segment_o;

  seg_t seg_q[$];
  seg_t want_seg;
  int mismatches = 0;
  int seg_count = 0;
  int cycle_count = 0;
  bit tx_stall = 1'b1;
  bit rx_stall = 1'b1;
  int sink_hold_cycles = 0;

  cubic_curve_segment_generator_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .end_a_x_i      (curve_drv.end_a_x),
    .end_a_ytop_i   (curve_drv.end_a_ytop),
    .end_a_ybot_i   (curve_drv.end_a_ybot),
    .end_b_x_i      (curve_drv.end_b_x),
    .end_b_ytop_i   (curve_drv.end_b_ytop),
    .end_b_ybot_i   (curve_drv.end_b_ybot),
    .near_x_i       (curve_drv.near_x),
    .near_ytop_i    (curve_drv.near_ytop),
    .near_ybot_i    (curve_drv.near_ybot),
    .far_x_i        (curve_drv.far_x),
    .far_ytop_i     (curve_drv.far_ytop),
    .far_ybot_i     (curve_drv.far_ybot),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cur_x_o        (cur_x_o),
    .cur_y_o        (cur_y_o),
    .prev_x_o       (prev_x_o),
    .prev_y_o       (prev_y_o),
    .last_segment_o (last_segment_o)
  );

  always #6 clk_i = ~clk_i;

  // curve math in q16
  function automatic longint round_q(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint third_q16(longint n);
    longint num;
    num = n * (longint'(2) <<< FRAC) + 3;
    if (num >= 0) return num / 6;
    return -((-num + 5) / 6);
  endfunction

  function automatic longint pixel(logic [IN_W-1:0] v);
    return longint'(v) & ((longint'(1) <<< COORD_BITS) - 1);
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_q8(longint v);
    longint r;
    r = v;
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return r[OUT_W-1:0];
  endfunction

  function automatic poly_t axis_poly(longint p0, longint p1, longint p2, longint p3);
    poly_t c;
    c.c3 = third_q16(16 * p3 - 32 * p2 + 32 * p1 - 16 * p0);
    c.c2 = third_q16(-16 * p3 + 40 * p2 - 56 * p1 + 32 * p0);
    c.c1 = third_q16(3 * p3 - 8 * p2 + 24 * p1 - 19 * p0);
    c.c0 = p0 <<< FRAC;
    return c;
  endfunction

  function automatic longint horner_q8(poly_t c, longint t);
    longint acc;
    acc = c.c3;
    acc = round_q(acc * t, FRAC) + c.c2;
    acc = round_q(acc * t, FRAC) + c.c1;
    acc = round_q(acc * t, FRAC) + c.c0;
    return round_q(acc, FRAC - 8);
  endfunction

  function automatic void predict_segments(curve_in_t c);
    longint ax, ay, bx, by, nx, ny, fx, fy;
    longint x0, y0, x3, y3, t, cx, cy, px, py;
    poly_t kx, ky;
    seg_t s;
    ax = pixel(c.end_a_x);
    ay = (pixel(c.end_a_ytop) + pixel(c.end_a_ybot)) / 2;
    bx = pixel(c.end_b_x);
    by = (pixel(c.end_b_ytop) + pixel(c.end_b_ybot)) / 2;
    nx = pixel(c.near_x);
    ny = (pixel(c.near_ytop) + pixel(c.near_ybot)) / 2;
    fx = pixel(c.far_x);
    fy = (pixel(c.far_ytop) + pixel(c.far_ybot)) / 2;
    // equal end x puts end b first
    if (ax < bx) begin
      x0 = ax; y0 = ay; x3 = bx; y3 = by;
    end else begin
      x0 = bx; y0 = by; x3 = ax; y3 = ay;
    end
    kx = axis_poly(x0, nx, fx, x3);
    ky = axis_poly(y0, ny, fy, y3);
    px = x0 * 256;
    py = y0 * 256;
    for (int k = 0; k <= STEPS; k++) begin
      t = (longint'(k) * (longint'(2) <<< FRAC) + STEPS) / (2 * STEPS);
      cx = horner_q8(kx, t);
      cy = horner_q8(ky, t);
      s.cx = clamp_q8(cx);
      s.cy = clamp_q8(cy);
      s.px = clamp_q8(px);
      s.py = clamp_q8(py);
      s.last = (k == STEPS);
      seg_q = {seg_q, s};
      px = cx;
      py = cy;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at segment %0d: %s", seg_count, msg);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (seg_q.size() == 0) begin
        report_mismatch("segment with nothing expected");
      end else begin
        want_seg = seg_q.pop_front();
        if (cur_x_o !== want_seg.cx)
          report_mismatch($sformatf("cur_x %0d want %0d", cur_x_o, want_seg.cx));
        if (cur_y_o !== want_seg.cy)
          report_mismatch($sformatf("cur_y %0d want %0d", cur_y_o, want_seg.cy));
        if (prev_x_o !== want_seg.px)
          report_mismatch($sformatf("prev_x %0d want %0d", prev_x_o, want_seg.px));
        if (prev_y_o !== want_seg.py)
          report_mismatch($sformatf("prev_y %0d want %0d", prev_y_o, want_seg.py));
        if (last_segment_o !== want_seg.last)
          report_mismatch($sformatf("last_segment %0b want %0b", last_segment_o,
                                    want_seg.last));
      end
      seg_count++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d segments outstanding", seg_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // output side ready control
  initial begin : sink
    int gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold_cycles > 0) begin
        gap = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        gap = rx_stall ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic send_curve(input curve_in_t c);
    int gap;
    gap = tx_stall ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    curve_drv <= c;
    do @(posedge clk_i); while (!in_ready_o);
    predict_segments(c);
  endtask

  task automatic drain_segments();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (seg_q.size() != 0);
  endtask

  function automatic curve_in_t make_curve(int e_ax, int e_ayt, int e_ayb, int e_bx,
                                           int e_byt, int e_byb, int n_x, int n_yt,
                                           int n_yb, int f_x, int f_yt, int f_yb);
    curve_in_t c;
    c.end_a_x = IN_W'(e_ax);  c.end_a_ytop = IN_W'(e_ayt);  c.end_a_ybot = IN_W'(e_ayb);
    c.end_b_x = IN_W'(e_bx);  c.end_b_ytop = IN_W'(e_byt);  c.end_b_ybot = IN_W'(e_byb);
    c.near_x  = IN_W'(n_x);   c.near_ytop  = IN_W'(n_yt);   c.near_ybot  = IN_W'(n_yb);
    c.far_x   = IN_W'(f_x);   c.far_ytop   = IN_W'(f_yt);   c.far_ybot   = IN_W'(f_yb);
    return c;
  endfunction

  function automatic curve_in_t rand_curve();
    curve_in_t c;
    int pick;
    logic [159:0] rnd;
    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
    c = rnd[$bits(curve_in_t)-1:0];
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      c.end_b_x = c.end_a_x;
    end else if (pick == 1) begin
      // corner values only
      for (int i = 0; i < 12; i++)
        c[i*IN_W +: IN_W] = $urandom_range(0, 1) ? '1 : '0;
    end else if (pick == 2) begin
      c.end_b_x = IN_W'(c.end_a_x + $urandom_range(0, 1) - $urandom_range(0, 1));
    end
    return c;
  endfunction

  task automatic test_directed();
    localparam int M = 4095;
    tx_stall = 1'b1;
    rx_stall = 1'b1;
    send_curve(make_curve(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_curve(make_curve(M, M, M, M, M, M, M, M, M, M, M, M));
    send_curve(make_curve(0, 0, 0, M, M, M, 1365, 1365, 1365, 2730, 2730, 2730));
    send_curve(make_curve(M, M, M, 0, 0, 0, 1365, 1365, 1365, 2730, 2730, 2730));
    send_curve(make_curve(100, 10, 20, 100, 3000, 3001, 50, 0, 1, 150, M, 0));
    send_curve(make_curve(2048, 0, M, 2048, M, 0, 0, 0, 0, M, M, M));
    send_curve(make_curve(0, 0, 0, M, 0, 0, M, M, M, 0, 0, 0));
    send_curve(make_curve(0, M, M, M, M, M, 0, 0, 0, M, 0, 0));
    send_curve(make_curve(M, 0, 0, 0, M, M, M, M, M, 0, 0, 0));
    send_curve(make_curve(0, 0, 0, M, M, M, M, 0, 0, 0, M, M));
    send_curve(make_curve(M, 0, 0, 0, 0, 0, 0, M, M, M, M, M));
    send_curve(make_curve(1, 1, 2, 2, 3, 4, 5, 6, 7, 8, 9, 10));
    send_curve(make_curve(M, 1, 0, M - 1, 0, 1, 0, M, M - 1, M, 1, 2));
    send_curve(make_curve(0, 3, 0, 0, 0, 3, M, 0, M, 0, M, 0));
    send_curve(make_curve(2730, 555, 556, 1365, 4000, 1, 0, M, 0, M, 0, M));
    send_curve(make_curve(1000, 0, 0, 1001, M, M, M, 0, 0, 0, M, M));
    send_curve(make_curve(1001, M, M, 1000, 0, 0, 0, M, M, M, 0, 0));
    send_curve(make_curve(2047, 2048, 2049, 2048, 2047, 2046, 2049, 1, 4094, 2046,
                          4094, 1));
    drain_segments();
  endtask

  task automatic test_random_stream();
    for (int blk = 0; blk < 6; blk++) begin
      tx_stall = ($urandom_range(0, 3) != 0);
      rx_stall = ($urandom_range(0, 3) != 0);
      repeat (20) send_curve(rand_curve());
    end
  endtask

  task automatic test_output_backpressure();
    drain_segments();
    tx_stall = 1'b0;
    rx_stall = 1'b1;
    sink_hold_cycles = 300;
    repeat (8) send_curve(rand_curve());
    drain_segments();
  endtask

  task automatic test_input_pause();
    tx_stall = 1'b1;
    rx_stall = 1'b0;
    repeat (6) send_curve(rand_curve());
    drain_segments();
    tx_stall = 1'b0;
    repeat (6) send_curve(rand_curve());
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_stream();
    test_output_backpressure();
    test_input_pause();
    rx_stall = 1'b0;
    drain_segments();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ccsg_pkg.sv
rtl/ccsg_coef.sv
rtl/ccsg_seq.sv
rtl/ccsg_eval.sv
rtl/cubic_curve_segment_generator_unit.sv
tb/sv/tb.sv
